// ===== design/mof_pkg.sv =====
`timescale 1ns / 1ps

package mof_pkg;

   // Fixed field widths of the request and response items.
   localparam int SAMPLE_W      = 8;
   localparam int CHANNEL_W     = 3;
   // Number of channels that carry a sample field in a store request.
   localparam int SAMPLE_FIELDS = 2;

   localparam logic OP_STORE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                 op;
      logic [SAMPLE_W-1:0]  sample_ch0;
      logic [SAMPLE_W-1:0]  sample_ch1;
      logic [CHANNEL_W-1:0] channel;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] median;
      logic                channel_ok;
   } rsp_payload_type;

endpackage

// ===== design/mof_req_if.sv =====
`timescale 1ns / 1ps

interface mof_req_if
   import mof_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/mof_rsp_if.sv =====
`timescale 1ns / 1ps

interface mof_rsp_if
   import mof_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/mof_ram.sv =====
`timescale 1ns / 1ps

module mof_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 5
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/multichannel_median_of_five_filter.sv =====
`timescale 1ns / 1ps

// Median filter over a sliding window of WINDOW 8-bit samples for each of
// CHANNELS ADC channels. A store transfer (op 0) writes sample_ch0 and
// sample_ch1 into the shared current slot and advances the slot pointer,
// which wraps at WINDOW; it returns nothing. Channels two
// and above have no sample field and always hold zero. A query transfer
// (op 1) returns one response with the true median of the named channel's
// window (sorted position WINDOW/2, so the upper middle element for an even
// window) and channel_ok set, or median 0 with channel_ok clear when the
// channel does not exist. Slots never written count as zero samples. The
// windows live in one RAM with one row per slot, so a query reads WINDOW rows
// through its single read port, one per cycle, before the response is loaded;
// an out-of-range query reads no rows and goes straight to loading its answer.
// Reset clears a valid flag per row at once, so there is no clearing pass. A
// finished response waits in an output register and the next request is
// taken meanwhile.
module multichannel_median_of_five_filter
   import mof_pkg::*;
#(
   parameter int CHANNELS = 2,
   parameter int WINDOW   = 5
) (
   input  logic        clock,
   input  logic        reset,
   mof_req_if.sink     req,
   mof_rsp_if.source   rsp
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ROW_W  = CHANNELS * SAMPLE_W;
   localparam int MID    = WINDOW / 2;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SLOT_W-1:0]   cnt_ff, cnt_in;
   logic [WINDOW-1:0]   row_valid_ff, row_valid_in;
   logic                pend_ff, pend_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic                ch_ok_ff, ch_ok_in;
   logic [SAMPLE_W-1:0] sort_ff [WINDOW];
   logic [SAMPLE_W-1:0] sort_in [WINDOW];

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic                req_xfer;
   logic                ram_wr_en;
   logic [ROW_W-1:0]    ram_wr_data;
   logic                ram_rd_en;
   logic [ROW_W-1:0]    ram_rd_data;
   logic [SAMPLE_W-1:0] lane [CHANNELS];
   logic [SAMPLE_W-1:0] ins_value;
   logic [WINDOW-1:0]   gt;

   assign req.ready   = (state_ff == ST_IDLE);
   assign req_xfer    = req.valid && req.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // One RAM row per slot; each channel owns one byte lane of the row.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (c == 0) begin
            ram_wr_data[c*SAMPLE_W +: SAMPLE_W] = req.payload.sample_ch0;
         end else if (c == 1) begin
            ram_wr_data[c*SAMPLE_W +: SAMPLE_W] = req.payload.sample_ch1;
         end else begin
            ram_wr_data[c*SAMPLE_W +: SAMPLE_W] = '0;
         end
      end
   end

   assign ram_wr_en = req_xfer && (req.payload.op == OP_STORE);
   assign ram_rd_en = (state_ff == ST_READ);

   mof_ram #(
      .WIDTH (ROW_W),
      .DEPTH (WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cnt_ff),
      .rd_data (ram_rd_data)
   );

   // Pick the queried channel's byte out of the row just read. A row that
   // was never written since reset reads as zero.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         lane[c] = ram_rd_data[c*SAMPLE_W +: SAMPLE_W];
      end
      ins_value = pend_valid_ff ? lane[ch_ff] : '0;
   end

   // Insertion into an ascending list: every entry greater than the new
   // value moves up one place, and the value lands at the lowest such entry.
   // The list starts filled with all ones, which the real samples push out.
   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         gt[i] = (sort_ff[i] > ins_value);
      end
   end

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      cnt_in        = cnt_ff;
      row_valid_in  = row_valid_ff;
      pend_in       = 1'b0;
      pend_valid_in = row_valid_ff[cnt_ff];
      ch_in         = ch_ff;
      ch_ok_in      = ch_ok_ff;
      sort_in       = sort_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_data_in   = rsp_data_ff;

      if (pend_ff) begin
         for (int i = 0; i < WINDOW; i++) begin
            if (!gt[i]) begin
               sort_in[i] = sort_ff[i];
            end else if (i == 0) begin
               sort_in[i] = ins_value;
            end else if (!gt[i-1]) begin
               sort_in[i] = ins_value;
            end else begin
               sort_in[i] = sort_ff[i-1];
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req.payload.op == OP_STORE) begin
                  row_valid_in[slot_ff] = 1'b1;
                  slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
               end else begin
                  ch_in    = req.payload.channel[CH_W-1:0];
                  ch_ok_in = (32'(req.payload.channel) < CHANNELS);
                  cnt_in   = '0;
                  for (int i = 0; i < WINDOW; i++) begin
                     sort_in[i] = '1;
                  end
                  state_in = ch_ok_in ? ST_READ : ST_FINISH;
               end
            end
         end
         ST_READ: begin
            pend_in = 1'b1;
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // The last row's byte is inserted in this cycle.
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.median     = ch_ok_ff ? sort_ff[MID] : '0;
               rsp_data_in.channel_ok = ch_ok_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         cnt_ff       <= '0;
         row_valid_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         cnt_ff       <= cnt_in;
         row_valid_ff <= row_valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_valid_ff <= pend_valid_in;
      ch_ff         <= ch_in;
      ch_ok_ff      <= ch_ok_in;
      sort_ff       <= sort_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
